// ----- src/ucord_pkg.sv -----
// ----------------------------------------------------------------------------
// ucord_pkg: shared types, codes and constant functions for the CORDIC engine
// Holds the command codes, the per-cell control bundle, the default sizes and
// the functions that build the angle constants while the design elaborates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucord_pkg;

  // Default sizes of the datapath.
  localparam int UCORD_ITERATIONS    = 26;
  localparam int UCORD_WORD_WIDTH    = 32;
  localparam int UCORD_FRACTION_BITS = 26;

  // Stream port widths.
  localparam int IN_TDATA_W  = 128;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 96;

  // Command codes as they arrive on the input stream.
  localparam logic [1:0] CMD_LINEAR     = 2'd0;
  localparam logic [1:0] CMD_CIRCULAR   = 2'd1;
  localparam logic [1:0] CMD_HYPERBOLIC = 2'd2;

  typedef enum logic [1:0] {
    COORD_LINEAR,
    COORD_CIRCULAR,
    COORD_HYPERBOLIC
  } coord_t;

  // Control bundle that travels with each vector from cell to cell.
  typedef struct packed {
    logic   valid;
    coord_t coord;
    logic   vec;
  } ctl_t;

  // Shift-subtract division, used only while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sum of (+/-) p_k/(2k+1) with 64 fraction bits; p shrinks by div, or by
  // 4^-sh when div is zero.
  function automatic logic [63:0] series(input logic [63:0] p, input logic [63:0] div,
                                         input int sh, input bit alt);
    logic [63:0] sum;
    logic [63:0] pw;
    logic [63:0] term;
    sum = '0;
    pw  = p;
    for (int k = 0; k < 64; k++) begin
      if (pw != 64'd0) begin
        term = udiv64(pw, 64'(2 * k + 1));
        if (alt && k[0]) sum = sum - term;
        else             sum = sum + term;
        if (div != 64'd0)  pw = udiv64(pw, div);
        else if (2 * sh < 64) pw = pw >> (2 * sh);
        else               pw = '0;
      end
    end
    return sum;
  endfunction

  // Round half up from 64 fraction bits to frac fraction bits.
  function automatic logic [63:0] to_fix(input logic [63:0] v, input int frac);
    logic [63:0] t;
    t = v >> (63 - frac);
    t = (t + 64'd1) >> 1;
    return t;
  endfunction

  function automatic logic [63:0] circ_fix(input int s, input int frac);
    logic [63:0] a5;
    logic [63:0] a239;
    if (s == 0) begin
      // Machin's formula gives pi/4 for the first step.
      a5   = series(udiv64({64{1'b1}}, 64'd5), 64'd25, 0, 1'b1);
      a239 = series(udiv64({64{1'b1}}, 64'd239), 64'd57121, 0, 1'b1);
      return to_fix((a5 << 2) - a239, frac);
    end
    return to_fix(series(64'd1 << (64 - s), 64'd0, s, 1'b1), frac);
  endfunction

  function automatic logic [63:0] hyp_fix(input int s, input int frac);
    if (s == 0) return 64'd0;
    return to_fix(series(64'd1 << (64 - s), 64'd0, s, 1'b0), frac);
  endfunction

  function automatic logic [63:0] lin_fix(input int s, input int frac);
    if (s <= frac) return 64'd1 << (frac - s);
    if (s == frac + 1) return 64'd1;
    return 64'd0;
  endfunction

  // Shift applied by a cell in hyperbolic mode; shifts 4, 7, 10 and so on
  // occupy two cells each.
  function automatic int hyp_shift(input int k);
    int pos;
    int res;
    pos = 0;
    res = 1;
    for (int i = 0; i < 64; i++) begin
      if (k >= pos) res = i + 1;
      pos = pos + ((i >= 3 && (i % 3) == 0) ? 2 : 1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/ucord_cell.sv -----
// ----------------------------------------------------------------------------
// ucord_cell: one micro-rotation of the CORDIC chain
// Applies a fixed shift and angle constant chosen by the coordinate system and
// registers the vector for the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucord_cell #(
  parameter int ITERATIONS    = ucord_pkg::UCORD_ITERATIONS,
  parameter int WORD_WIDTH    = ucord_pkg::UCORD_WORD_WIDTH,
  parameter int FRACTION_BITS = ucord_pkg::UCORD_FRACTION_BITS,
  parameter int CELL_INDEX    = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  ucord_pkg::ctl_t              ctl_i,
  input  logic signed [WORD_WIDTH-1:0] x_i,
  input  logic signed [WORD_WIDTH-1:0] y_i,
  input  logic signed [WORD_WIDTH-1:0] z_i,
  input  logic signed [WORD_WIDTH-1:0] level_i,
  output ucord_pkg::ctl_t              ctl_o,
  output logic signed [WORD_WIDTH-1:0] x_o,
  output logic signed [WORD_WIDTH-1:0] y_o,
  output logic signed [WORD_WIDTH-1:0] z_o,
  output logic signed [WORD_WIDTH-1:0] level_o
);
  import ucord_pkg::*;

  // Circular and linear use the first ITERATIONS cells; later cells pass.
  localparam bit CL_ACTIVE = (CELL_INDEX < ITERATIONS);
  localparam int SH_CL     = CL_ACTIVE ? CELL_INDEX : 0;
  localparam int SH_HY     = hyp_shift(CELL_INDEX);

  localparam logic signed [WORD_WIDTH-1:0] K_CIRC =
    WORD_WIDTH'(circ_fix(SH_CL, FRACTION_BITS));
  localparam logic signed [WORD_WIDTH-1:0] K_HYP =
    WORD_WIDTH'(hyp_fix(SH_HY, FRACTION_BITS));
  localparam logic signed [WORD_WIDTH-1:0] K_LIN =
    WORD_WIDTH'(lin_fix(SH_CL, FRACTION_BITS));

  ctl_t                         ctl_r;
  logic signed [WORD_WIDTH-1:0] x_r, y_r, z_r, level_r;
  logic signed [WORD_WIDTH-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [WORD_WIDTH-1:0] xs_cl, ys_cl, xs_hy, ys_hy;
  logic                         up;

  assign xs_cl = x_i >>> SH_CL;
  assign ys_cl = y_i >>> SH_CL;
  assign xs_hy = x_i >>> SH_HY;
  assign ys_hy = y_i >>> SH_HY;

  // Vectoring drives y toward the level, rotation drives z toward zero.
  assign up = ctl_i.vec ? (y_i < level_i) : !z_i[WORD_WIDTH-1];

  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    case (ctl_i.coord)
      COORD_CIRCULAR: begin
        if (CL_ACTIVE) begin
          x_nxt = up ? x_i - ys_cl : x_i + ys_cl;
          y_nxt = up ? y_i + xs_cl : y_i - xs_cl;
          z_nxt = up ? z_i - K_CIRC : z_i + K_CIRC;
        end
      end
      COORD_HYPERBOLIC: begin
        x_nxt = up ? x_i + ys_hy : x_i - ys_hy;
        y_nxt = up ? y_i + xs_hy : y_i - xs_hy;
        z_nxt = up ? z_i - K_HYP : z_i + K_HYP;
      end
      COORD_LINEAR: begin
        if (CL_ACTIVE) begin
          y_nxt = up ? y_i + xs_cl : y_i - xs_cl;
          z_nxt = up ? z_i - K_LIN : z_i + K_LIN;
        end
      end
      default: begin
        x_nxt = x_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      z_r     <= z_nxt;
      level_r <= level_i;
    end
  end

  assign ctl_o   = ctl_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign level_o = level_r;

endmodule

`default_nettype wire

// ----- src/ucord_skid.sv -----
// ----------------------------------------------------------------------------
// ucord_skid: two-entry output buffer of the CORDIC engine
// Holds finished results for the output stream and gives the cell chain a
// registered advance signal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucord_skid #(
  parameter int DATA_W = ucord_pkg::OUT_TDATA_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [DATA_W-1:0] in_data,
  output logic              in_ready,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_data,
  input  logic              out_ready
);
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [DATA_W-1:0] skid_data_r, skid_data_nxt;
  logic              push;

  assign in_ready = !skid_valid_r;
  assign push     = in_valid && !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_ready || !out_valid_r) begin
      // The output register frees up: the older held result goes first.
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = in_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- src/unified_cordic_engine.sv -----
// ----------------------------------------------------------------------------
// unified_cordic_engine: circular, linear and hyperbolic CORDIC
// The engine accepts one vector per clock while the output buffer has room and
// returns one result per vector in the order received. Each vector walks a
// chain of ITERATIONS + floor((ITERATIONS - 1) / 3) cells, one micro-rotation
// per cell (34 cells at the default of 26 iterations), and then enters a
// two-entry output buffer; vectors of every coordinate system take this same
// path of cell registers and buffer output register. Circular and linear
// vectors pass the trailing cells that hyperbolic mode needs for its repeated
// shifts. The chain advances as long as the output buffer has room, and input
// ready only drops after the output has been held back for two results. No
// gain correction is applied and all sums wrap in two's complement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unified_cordic_engine #(
  parameter int ITERATIONS    = ucord_pkg::UCORD_ITERATIONS,
  parameter int WORD_WIDTH    = ucord_pkg::UCORD_WORD_WIDTH,
  parameter int FRACTION_BITS = ucord_pkg::UCORD_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // target_level[30:0], x_in[62:31], y_in[94:63], z_in[126:95], zero pad[127]
  input  logic [ucord_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command[1:0], vectoring[2]
  input  logic [ucord_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // x_out[31:0], y_out[63:32], z_out[95:64]
  output logic [ucord_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ucord_pkg::*;

  localparam int NUM_CELLS = ITERATIONS + (ITERATIONS - 1) / 3;

  ctl_t                         ctl   [0:NUM_CELLS];
  logic signed [WORD_WIDTH-1:0] xw    [0:NUM_CELLS];
  logic signed [WORD_WIDTH-1:0] yw    [0:NUM_CELLS];
  logic signed [WORD_WIDTH-1:0] zw    [0:NUM_CELLS];
  logic signed [WORD_WIDTH-1:0] lw    [0:NUM_CELLS];
  logic                         adv;
  coord_t                       coord_in;

  always_comb begin
    case (in_tuser[1:0])
      CMD_CIRCULAR:   coord_in = COORD_CIRCULAR;
      CMD_HYPERBOLIC: coord_in = COORD_HYPERBOLIC;
      CMD_LINEAR:     coord_in = COORD_LINEAR;
      default:        coord_in = COORD_LINEAR;
    endcase
  end

  assign ctl[0].valid = in_tvalid;
  assign ctl[0].coord = coord_in;
  assign ctl[0].vec   = in_tuser[2];

  assign xw[0] = WORD_WIDTH'(signed'(in_tdata[62:31]));
  assign yw[0] = WORD_WIDTH'(signed'(in_tdata[94:63]));
  assign zw[0] = WORD_WIDTH'(signed'(in_tdata[126:95]));
  // The target level only matters for circular vectors.
  assign lw[0] = (coord_in == COORD_CIRCULAR) ? WORD_WIDTH'(in_tdata[30:0]) : '0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    ucord_cell #(
      .ITERATIONS    (ITERATIONS),
      .WORD_WIDTH    (WORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS),
      .CELL_INDEX    (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .ctl_i   (ctl[k]),
      .x_i     (xw[k]),
      .y_i     (yw[k]),
      .z_i     (zw[k]),
      .level_i (lw[k]),
      .ctl_o   (ctl[k+1]),
      .x_o     (xw[k+1]),
      .y_o     (yw[k+1]),
      .z_o     (zw[k+1]),
      .level_o (lw[k+1])
    );
  end

  ucord_skid #(
    .DATA_W (OUT_TDATA_W)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ctl[NUM_CELLS].valid && adv),
    .in_data   ({32'(zw[NUM_CELLS]), 32'(yw[NUM_CELLS]), 32'(xw[NUM_CELLS])}),
    .in_ready  (adv),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_ready (out_tready)
  );

  assign in_tready = adv;

endmodule

`default_nettype wire

// ----- src/ucord_chk.sv -----
// ----------------------------------------------------------------------------
// ucord_chk: port-level checks for the CORDIC engine
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucord_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [ucord_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [ucord_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ucord_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A held result stays offered until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before its transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("held result changed before its transaction");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // Input back-pressure only happens while a result is waiting.
  a_ready_backed: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input ready dropped without an output stall");

endmodule

bind unified_cordic_engine ucord_chk u_chk (.*);

`default_nettype wire
